// File: rtl/servo_bus_packet_framer_parser_assert.svh
// ----------------------------------------------------------------------------
// servo bus framer assertion macros
// shared concurrent assertion forms for the servo bus framer and parser
// ----------------------------------------------------------------------------
`ifndef SERVO_BUS_PACKET_FRAMER_PARSER_ASSERT_SVH
`define SERVO_BUS_PACKET_FRAMER_PARSER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SBPFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SBPFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sbpfp_pkg.sv
// ----------------------------------------------------------------------------
// sbpfp_pkg
// types, codes and packet constants of the servo bus framer and parser
// ----------------------------------------------------------------------------
package sbpfp_pkg;

   // command codes of a request word
   localparam logic [1:0] CMD_READ = 2'd0;
   localparam logic [1:0] CMD_SYNC = 2'd1;
   localparam logic [1:0] CMD_RX   = 2'd2;

   // result kinds
   localparam logic KIND_TX    = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   // reply error codes
   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_HEADER   = 2'd1;
   localparam logic [1:0] ERR_ID       = 2'd2;
   localparam logic [1:0] ERR_CHECKSUM = 2'd3;

   // control register indexes
   localparam logic [1:0] CSR_REPLY_HDR = 2'd0;
   localparam logic [1:0] CSR_READ_ADDR = 2'd1;
   localparam logic [1:0] CSR_SYNC_ADDR = 2'd2;

   localparam logic [7:0] CSR_REPLY_HDR_RESET = 8'hF5;
   localparam logic [7:0] CSR_READ_ADDR_RESET = 8'h38;
   localparam logic [7:0] CSR_SYNC_ADDR_RESET = 8'h2A;

   // packet bytes
   localparam logic [7:0] HDR_BYTE      = 8'hFF;
   localparam logic [7:0] BROADCAST_ID  = 8'hFE;
   localparam logic [7:0] READ_LEN      = 8'h04;
   localparam logic [7:0] INST_READ     = 8'h02;
   localparam logic [7:0] READ_COUNT    = 8'h02;
   localparam logic [7:0] SYNC_LEN      = 8'h0E;
   localparam logic [7:0] INST_SYNC     = 8'h83;
   localparam logic [7:0] SYNC_DATA_LEN = 8'h04;

   // job kinds held in the queue
   localparam logic [1:0] JOB_READ  = 2'd0;
   localparam logic [1:0] JOB_SYNC  = 2'd1;
   localparam logic [1:0] JOB_REPLY = 2'd2;

   // byte index within a packet
   localparam int IDX_W = 5;
   localparam logic [IDX_W-1:0] READ_LAST_IDX = 5'd7;
   localparam logic [IDX_W-1:0] SYNC_LAST_IDX = 5'd17;

   // index of the checksum byte in a reply
   localparam logic [2:0] RX_LAST = 3'd7;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  servo_id_a;
      logic [15:0] angle_a;
      logic [15:0] move_time_a;
      logic [7:0]  servo_id_b;
      logic [15:0] angle_b;
      logic [15:0] move_time_b;
      logic [7:0]  rx_byte;
   } req_word_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [15:0] read_position;
      logic [7:0]  servo_status;
      logic [1:0]  error_code;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  id_a;
      logic [15:0] ang_a;
      logic [15:0] tim_a;
      logic [7:0]  id_b;
      logic [15:0] ang_b;
      logic [15:0] tim_b;
      logic [7:0]  addr;
      logic [15:0] position;
      logic [7:0]  status;
      logic [1:0]  err;
   } job_type;

   // packet byte at an index, checksum slot excluded
   function automatic logic [7:0] packet_byte(input job_type job,
                                              input logic [IDX_W-1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (job.kind == JOB_READ) begin
         case (idx)
            5'd0, 5'd1: b = HDR_BYTE;
            5'd2:       b = job.id_a;
            5'd3:       b = READ_LEN;
            5'd4:       b = INST_READ;
            5'd5:       b = job.addr;
            5'd6:       b = READ_COUNT;
            default:    b = 8'h00;
         endcase
      end else begin
         case (idx)
            5'd0, 5'd1: b = HDR_BYTE;
            5'd2:       b = BROADCAST_ID;
            5'd3:       b = SYNC_LEN;
            5'd4:       b = INST_SYNC;
            5'd5:       b = job.addr;
            5'd6:       b = SYNC_DATA_LEN;
            5'd7:       b = job.id_a;
            5'd8:       b = job.ang_a[15:8];
            5'd9:       b = job.ang_a[7:0];
            5'd10:      b = job.tim_a[15:8];
            5'd11:      b = job.tim_a[7:0];
            5'd12:      b = job.id_b;
            5'd13:      b = job.ang_b[15:8];
            5'd14:      b = job.ang_b[7:0];
            5'd15:      b = job.tim_b[15:8];
            5'd16:      b = job.tim_b[7:0];
            default:    b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

// File: rtl/sbpfp_chan_if.sv
// ----------------------------------------------------------------------------
// sbpfp_chan_if
// valid/ready channel carrying one word of a given payload type
// ----------------------------------------------------------------------------
interface sbpfp_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/sbpfp_job_queue.sv
// ----------------------------------------------------------------------------
// sbpfp_job_queue
// small register queue of jobs between the front and back ends
// ----------------------------------------------------------------------------
module sbpfp_job_queue
   import sbpfp_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type             slot_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/sbpfp_front.sv
// ----------------------------------------------------------------------------
// sbpfp_front
// accepts request words, holds control registers and parses reply bytes
// ----------------------------------------------------------------------------
module sbpfp_front
   import sbpfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sbpfp_chan_if.sink req_bus,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output logic       push_valid,
   input  logic       push_ready,
   output job_type    push_job
);

   req_word_type word;
   logic         accept;
   logic         rx_take, rx_store_en, rx_finish;

   logic [7:0]   hdr_cfg_ff, read_addr_ff, sync_addr_ff;
   logic [2:0]   rx_count_ff, rx_count_in;
   logic [7:0]   expected_id_ff, expected_id_in;
   logic         pending_ff, pending_in;
   logic [7:0]   rx_store_ff [7];

   logic [7:0]   sum;
   logic [1:0]   err;

   assign word        = req_bus.payload;
   assign req_bus.ready = push_ready;
   assign accept      = req_bus.valid && push_ready;
   assign rx_take     = accept && (word.command == CMD_RX) && pending_ff;
   assign rx_store_en = rx_take && (rx_count_ff != RX_LAST);
   assign rx_finish   = rx_take && (rx_count_ff == RX_LAST);

   // reply check on the eighth byte
   always_comb begin
      sum = rx_store_ff[2] + rx_store_ff[3] + rx_store_ff[4] + rx_store_ff[5]
            + rx_store_ff[6];
      if (rx_store_ff[0] != HDR_BYTE || rx_store_ff[1] != hdr_cfg_ff) begin
         err = ERR_HEADER;
      end else if (rx_store_ff[2] != expected_id_ff) begin
         err = ERR_ID;
      end else if (word.rx_byte != ~sum) begin
         err = ERR_CHECKSUM;
      end else begin
         err = ERR_OK;
      end
   end

   always_comb begin
      push_job       = '0;
      push_job.id_a  = word.servo_id_a;
      push_job.ang_a = word.angle_a;
      push_job.tim_a = word.move_time_a;
      push_job.id_b  = word.servo_id_b;
      push_job.ang_b = word.angle_b;
      push_job.tim_b = word.move_time_b;
      push_job.err   = err;
      push_valid     = 1'b0;
      case (word.command)
         CMD_READ: begin
            push_job.kind = JOB_READ;
            push_job.addr = read_addr_ff;
            push_valid    = req_bus.valid;
         end
         CMD_SYNC: begin
            push_job.kind = JOB_SYNC;
            push_job.addr = sync_addr_ff;
            push_valid    = req_bus.valid;
         end
         CMD_RX: begin
            push_job.kind = JOB_REPLY;
            push_valid    = req_bus.valid && pending_ff && (rx_count_ff == RX_LAST);
         end
         default: begin
            push_job.kind = JOB_REPLY;
         end
      endcase
      if (err == ERR_OK) begin
         push_job.position = {rx_store_ff[5], rx_store_ff[6]};
         push_job.status   = rx_store_ff[4];
      end
   end

   always_comb begin
      rx_count_in    = rx_count_ff;
      expected_id_in = expected_id_ff;
      pending_in     = pending_ff;
      if (accept && word.command == CMD_READ) begin
         rx_count_in    = '0;
         expected_id_in = word.servo_id_a;
         pending_in     = 1'b1;
      end else if (rx_finish) begin
         rx_count_in = '0;
         pending_in  = 1'b0;
      end else if (rx_store_en) begin
         rx_count_in = rx_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cfg_ff     <= CSR_REPLY_HDR_RESET;
         read_addr_ff   <= CSR_READ_ADDR_RESET;
         sync_addr_ff   <= CSR_SYNC_ADDR_RESET;
         rx_count_ff    <= '0;
         expected_id_ff <= '0;
         pending_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_REPLY_HDR: hdr_cfg_ff   <= csr_wdata;
               CSR_READ_ADDR: read_addr_ff <= csr_wdata;
               CSR_SYNC_ADDR: sync_addr_ff <= csr_wdata;
               default:       ;
            endcase
         end
         rx_count_ff    <= rx_count_in;
         expected_id_ff <= expected_id_in;
         pending_ff     <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rx_store_en) begin
         rx_store_ff[rx_count_ff] <= word.rx_byte;
      end
   end

endmodule

// File: rtl/sbpfp_back.sv
// ----------------------------------------------------------------------------
// sbpfp_back
// serialises queued jobs into result words through an output register
// ----------------------------------------------------------------------------
module sbpfp_back
   import sbpfp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  job_type      pop_job,
   sbpfp_chan_if.source rsp_bus
);

   job_type          job_ff;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic             slot_free, emit, at_last, done, load;
   logic [IDX_W-1:0] last_idx;
   logic [7:0]       tx;

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_word_ff;

   always_comb begin
      case (job_ff.kind)
         JOB_READ: last_idx = READ_LAST_IDX;
         JOB_SYNC: last_idx = SYNC_LAST_IDX;
         default:  last_idx = '0;
      endcase
   end

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit      = busy_ff && slot_free;
   assign at_last   = (idx_ff == last_idx);
   assign done      = emit && at_last;
   assign pop_ready = !busy_ff || done;
   assign load      = pop_valid && pop_ready;
   assign tx        = at_last ? ~sum_ff : packet_byte(job_ff, idx_ff);

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_word_in  = rsp_word_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = '0;
         if (job_ff.kind == JOB_REPLY) begin
            rsp_word_in.kind          = KIND_REPLY;
            rsp_word_in.last          = 1'b1;
            rsp_word_in.read_position = job_ff.position;
            rsp_word_in.servo_status  = job_ff.status;
            rsp_word_in.error_code    = job_ff.err;
         end else begin
            rsp_word_in.kind    = KIND_TX;
            rsp_word_in.tx_byte = tx;
            rsp_word_in.last    = at_last;
         end
         idx_in = idx_ff + 1'b1;
         // header bytes stay out of the checksum
         if (idx_ff >= 5'd2) begin
            sum_in = sum_ff + tx;
         end
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
         sum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      rsp_word_ff <= rsp_word_in;
      if (load) begin
         job_ff <= pop_job;
      end
   end

endmodule

// File: rtl/servo_bus_packet_framer_parser.sv
// path: each job passes the queue, the serialiser's job register and its output register
// throughput: one request word per cycle while the job queue has room, one result word
// per cycle out of the serialiser while the receiver is ready; read packets are 8 words,
// sync writes 18, replies 1; the serialiser's byte counter sets the packet rate; the queue
// depth sets how far ahead the front end may run
// reset: synchronous, active high; clears control state and restores register defaults
// ----------------------------------------------------------------------------
// servo_bus_packet_framer_parser
// frames read and dual sync write packets and parses read replies
// ----------------------------------------------------------------------------
`include "servo_bus_packet_framer_parser_assert.svh"

module servo_bus_packet_framer_parser
   import sbpfp_pkg::*;
#(
   // jobs that may wait between the front end and the serialiser
   parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   sbpfp_chan_if.sink   req_bus,
   sbpfp_chan_if.source rsp_bus,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   // front end to queue
   logic    q_push_valid, q_push_ready;
   job_type q_push_job;

   // queue to serialiser
   logic    q_pop_valid, q_pop_ready;
   job_type q_pop_job;

   // front end: takes each word, updates the reply parser and hands
   // a job to the queue for every word that gives results
   sbpfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_job   (q_push_job)
   );

   // decouples the two sides: a long packet holds up parsing only once the queue is full
   sbpfp_job_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_job   (q_push_job),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_job    (q_pop_job)
   );

   // back end: one result word per cycle while the receiver is ready, checksum built on the fly
   sbpfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_job   (q_pop_job),
      .rsp_bus   (rsp_bus)
   );

   // a reply always closes its own result sequence
   `SBPFP_ASSERT_NOW(a_reply_last, clock, reset,
      rsp_bus.valid && rsp_bus.payload.kind == KIND_REPLY, rsp_bus.payload.last,
      "reply word without last flag")

   // faulty replies carry no position or status
   `SBPFP_ASSERT_NOW(a_err_clears, clock, reset,
      rsp_bus.valid && rsp_bus.payload.error_code != ERR_OK,
      rsp_bus.payload.read_position == 16'h0000 && rsp_bus.payload.servo_status == 8'h00,
      "faulty reply carries data")

   // a waiting job is never dropped by the queue
   `SBPFP_ASSERT_NEXT(a_job_held, clock, reset,
      q_pop_valid && !q_pop_ready, q_pop_valid,
      "queued job lost")

endmodule

// File: sim/servo_bus_packet_framer_parser_tb.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_framer_parser_tb
// drives read requests, dual sync writes and reply bytes into the framer and
// parser, predicts every transmit and reply word and checks each one in order
// ----------------------------------------------------------------------------
module servo_bus_packet_framer_parser_tb;
   import sbpfp_pkg::*;

   // the one command code the package leaves unnamed
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int DUE_DEPTH     = 1024;

   // ways a generated reply can be spoilt
   typedef enum logic [2:0] {
      FAULT_NONE,
      FAULT_HDR_FIRST,
      FAULT_HDR_SECOND,
      FAULT_ID,
      FAULT_SUM,
      FAULT_HDR_ID_SUM,
      FAULT_ID_SUM
   } reply_fault_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   sbpfp_chan_if #(.payload_type(req_word_type)) req_ch ();
   sbpfp_chan_if #(.payload_type(rsp_word_type)) rsp_ch ();

   servo_bus_packet_framer_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the block's registers and parser state
   logic [7:0] shadow_reply_hdr   = CSR_REPLY_HDR_RESET;
   logic [7:0] shadow_read_addr   = CSR_READ_ADDR_RESET;
   logic [7:0] shadow_sync_addr   = CSR_SYNC_ADDR_RESET;
   logic [2:0] shadow_rx_count    = 3'd0;
   logic [7:0] shadow_rx_store [0:6];
   logic [7:0] shadow_expected_id = 8'h00;
   logic       shadow_read_pending = 1'b0;

   // result words still to come, oldest first, as a ring
   rsp_word_type due_rsp_words [DUE_DEPTH];
   int           due_wr = 0;
   int           due_rd = 0;
   // packet body being framed, header and checksum excluded
   logic [7:0]   tx_body [15];
   int           tx_len = 0;

   int mismatches  = 0;
   int cycle_count = 0;
   int live_items  = 0;   // words that framed or fed the parser
   int burst_left  = 0;
   bit pacing      = 1'b1;
   int stall_left  = 0;   // long receiver hold-off, counted down by the receiver

   // ------------------------------------------------------------------------
   // clock and cycle limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("servo_bus_packet_framer_parser_tb: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   function automatic void due_put(input rsp_word_type r);
      due_rsp_words[due_wr % DUE_DEPTH] = r;
      due_wr++;
   endfunction

   function automatic rsp_word_type due_take();
      rsp_word_type r;
      r = due_rsp_words[due_rd % DUE_DEPTH];
      due_rd++;
      return r;
   endfunction

   function automatic void body_add(input logic [7:0] b);
      tx_body[tx_len] = b;
      tx_len++;
   endfunction

   // wraps tx_body in FF FF ... checksum and queues one transmit word per byte
   function automatic void queue_frame();
      logic [7:0]   sum;
      rsp_word_type r;
      int           i;
      sum  = 8'h00;
      r    = '0;
      r.kind    = KIND_TX;
      r.tx_byte = HDR_BYTE;
      due_put(r);
      due_put(r);
      for (i = 0; i < tx_len; i++) begin
         sum       = sum + tx_body[i];
         r.tx_byte = tx_body[i];
         due_put(r);
      end
      r.tx_byte = ~sum;
      r.last    = 1'b1;
      due_put(r);
   endfunction

   // works out the words caused by one accepted request word
   function automatic void frame_and_parse(input req_word_type w);
      logic [7:0]   sum;
      logic [1:0]   err;
      rsp_word_type r;
      tx_len = 0;
      case (w.command)
         CMD_READ: begin
            body_add(w.servo_id_a);
            body_add(READ_LEN);
            body_add(INST_READ);
            body_add(shadow_read_addr);
            body_add(READ_COUNT);
            // a new read abandons any reply in progress
            shadow_rx_count     = 3'd0;
            shadow_expected_id  = w.servo_id_a;
            shadow_read_pending = 1'b1;
            queue_frame();
         end
         CMD_SYNC: begin
            body_add(BROADCAST_ID);
            body_add(SYNC_LEN);
            body_add(INST_SYNC);
            body_add(shadow_sync_addr);
            body_add(SYNC_DATA_LEN);
            body_add(w.servo_id_a);
            body_add(w.angle_a[15:8]);
            body_add(w.angle_a[7:0]);
            body_add(w.move_time_a[15:8]);
            body_add(w.move_time_a[7:0]);
            body_add(w.servo_id_b);
            body_add(w.angle_b[15:8]);
            body_add(w.angle_b[7:0]);
            body_add(w.move_time_b[15:8]);
            body_add(w.move_time_b[7:0]);
            queue_frame();
         end
         CMD_RX: begin
            // bytes with no read pending are dropped
            if (shadow_read_pending) begin
               if (shadow_rx_count != RX_LAST) begin
                  shadow_rx_store[shadow_rx_count] = w.rx_byte;
                  shadow_rx_count = shadow_rx_count + 3'd1;
               end else begin
                  // eighth byte is the checksum
                  sum = shadow_rx_store[2] + shadow_rx_store[3] + shadow_rx_store[4]
                      + shadow_rx_store[5] + shadow_rx_store[6];
                  if (shadow_rx_store[0] != HDR_BYTE || shadow_rx_store[1] != shadow_reply_hdr)
                     err = ERR_HEADER;
                  else if (shadow_rx_store[2] != shadow_expected_id)
                     err = ERR_ID;
                  else if (w.rx_byte != ~sum)
                     err = ERR_CHECKSUM;
                  else
                     err = ERR_OK;
                  shadow_rx_count     = 3'd0;
                  shadow_read_pending = 1'b0;
                  r = '0;
                  r.kind       = KIND_REPLY;
                  r.last       = 1'b1;
                  r.error_code = err;
                  if (err == ERR_OK) begin
                     r.read_position = {shadow_rx_store[5], shadow_rx_store[6]};
                     r.servo_status  = shadow_rx_store[4];
                  end
                  due_put(r);
               end
            end
         end
         default: ;   // unused code, state left alone
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   function automatic void note_mismatch(input string what, input rsp_word_type want,
                                         input rsp_word_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d, %s: want kind %0d tx %02h last %0d pos %04h ",
                  cycle_count, what, want.kind, want.tx_byte, want.last, want.read_position,
                  "status %02h err %0d / got kind %0d tx %02h last %0d pos %04h ",
                  want.servo_status, want.error_code, got.kind, got.tx_byte, got.last,
                  got.read_position, "status %02h err %0d", got.servo_status, got.error_code);
   endfunction

   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      rsp_word_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = rsp_ch.payload;
         if (due_wr == due_rd) begin
            note_mismatch("word with nothing due", '0, got);
         end else begin
            want = due_take();
            if (got.kind !== want.kind || got.tx_byte !== want.tx_byte
                || got.last !== want.last || got.read_position !== want.read_position
                || got.servo_status !== want.servo_status
                || got.error_code !== want.error_code)
               note_mismatch("field differs", want, got);
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: stalls on its own pattern, plus the long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : rsp_stall_pattern
      int mode;
      int mode_left;
      int phase;
      mode      = 0;
      mode_left = 0;
      phase     = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 80);
            end
            mode_left = mode_left - 1;
            phase     = (phase + 1) % 3;
            case (mode)
               0:       rsp_ch.ready <= 1'b1;                       // no stalls
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);  // mostly stalled
               default: rsp_ch.ready <= (phase != 0);               // two in three
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [7:0] pick8();
      if ($urandom_range(0, 7) == 0) return 8'h00;
      if ($urandom_range(0, 6) == 0) return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] pick16();
      if ($urandom_range(0, 7) == 0) return 16'h0000;
      if ($urandom_range(0, 6) == 0) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // every field random, so unused fields toggle too
   function automatic req_word_type any_word(input logic [1:0] cmd);
      req_word_type w;
      w.command     = cmd;
      w.servo_id_a  = pick8();
      w.angle_a     = pick16();
      w.move_time_a = pick16();
      w.servo_id_b  = pick8();
      w.angle_b     = pick16();
      w.move_time_b = pick16();
      w.rx_byte     = pick8();
      return w;
   endfunction

   // offers one word, bursts and gaps when pacing, predicts on acceptance
   task automatic send_word(input req_word_type w);
      int gap;
      if (pacing && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= w;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (w.command == CMD_READ || w.command == CMD_SYNC
          || (w.command == CMD_RX && shadow_read_pending))
         live_items++;
      frame_and_parse(w);
   endtask

   // sender idles until every due word has come, then lets the block settle
   task automatic wait_all_words();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (due_wr != due_rd) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [7:0] hdr, input logic [7:0] raddr,
                                input logic [7:0] saddr);
      wait_all_words();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_REPLY_HDR;
      csr_wdata <= hdr;
      @(negedge clock);
      csr_index <= CSR_READ_ADDR;
      csr_wdata <= raddr;
      @(negedge clock);
      csr_index <= CSR_SYNC_ADDR;
      csr_wdata <= saddr;
      @(negedge clock);
      csr_we <= 1'b0;
      shadow_reply_hdr = hdr;
      shadow_read_addr = raddr;
      shadow_sync_addr = saddr;
   endtask

   // feeds the first nbytes of a reply to the pending read, spoilt as asked
   task automatic send_reply(input reply_fault_type fault, input logic [7:0] status,
                             input logic [15:0] pos, input int nbytes, input bit noisy);
      logic [7:0]   rb [0:7];
      req_word_type w;
      int           i;
      rb[0] = HDR_BYTE;
      rb[1] = shadow_reply_hdr;
      rb[2] = shadow_expected_id;
      rb[3] = pick8();
      rb[4] = status;
      rb[5] = pos[15:8];
      rb[6] = pos[7:0];
      if (fault == FAULT_HDR_FIRST || fault == FAULT_HDR_ID_SUM)
         rb[0] = rb[0] ^ 8'($urandom_range(1, 255));
      if (fault == FAULT_HDR_SECOND)
         rb[1] = rb[1] ^ 8'($urandom_range(1, 255));
      if (fault == FAULT_ID || fault == FAULT_HDR_ID_SUM || fault == FAULT_ID_SUM)
         rb[2] = rb[2] ^ 8'($urandom_range(1, 255));
      rb[7] = ~(rb[2] + rb[3] + rb[4] + rb[5] + rb[6]);
      if (fault == FAULT_SUM || fault == FAULT_HDR_ID_SUM || fault == FAULT_ID_SUM)
         rb[7] = rb[7] ^ 8'($urandom_range(1, 255));
      for (i = 0; i < nbytes; i++) begin
         // ignored codes and sync writes must not disturb the parser
         if (noisy && $urandom_range(0, 19) == 0) send_word(any_word(CMD_UNUSED));
         if (noisy && $urandom_range(0, 29) == 0) send_word(any_word(CMD_SYNC));
         w = any_word(CMD_RX);
         w.rx_byte = rb[i];
         send_word(w);
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // dropped byte, unused code, sync writes with every field at its extremes
   task automatic test_framing_extremes();
      req_word_type w;
      send_word(any_word(CMD_RX));       // nothing pending, dropped
      send_word(any_word(CMD_UNUSED));
      w = '0;
      w.command = CMD_SYNC;
      send_word(w);
      w = '1;
      w.command = CMD_SYNC;
      send_word(w);
   endtask

   // abandoned read, sync write while a reply is awaited, clean reply, reply with header, id and checksum all spoilt
   task automatic test_reply_checks();
      req_word_type w;
      w = any_word(CMD_READ);
      w.servo_id_a = 8'h00;
      send_word(w);
      send_reply(FAULT_NONE, 8'h00, 16'h0000, 3, 1'b0);
      w = any_word(CMD_READ);
      w.servo_id_a = 8'hFF;
      send_word(w);
      send_word(any_word(CMD_SYNC));
      send_reply(FAULT_NONE, 8'h00, 16'hFFFF, 8, 1'b0);
      send_word(any_word(CMD_READ));
      send_reply(FAULT_HDR_ID_SUM, 8'hFF, 16'h0000, 8, 1'b0);
   endtask

   // mostly whole read transactions, some cut short, with sync writes and noise
   task automatic test_random_traffic(input int n);
      int              target;
      int              pick;
      int              nbytes;
      reply_fault_type fault;
      target = live_items + n;
      while (live_items < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            send_word(any_word(CMD_READ));
            nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
            fault  = ($urandom_range(0, 1) == 0) ? FAULT_NONE
                                                 : reply_fault_type'(3'($urandom_range(1, 6)));
            send_reply(fault, pick8(), pick16(), nbytes, 1'b1);
         end else if (pick < 85) begin
            send_word(any_word(CMD_SYNC));
         end else if (pick < 93) begin
            send_word(any_word(CMD_RX));      // stray byte
         end else begin
            send_word(any_word(CMD_UNUSED));
         end
      end
   endtask

   // register settings: all low, all high, random, then back to defaults
   task automatic test_settings_sweep();
      load_settings(8'h00, 8'h00, 8'h00);
      test_random_traffic(70);
      load_settings(8'hFF, 8'hFF, 8'hFF);
      test_random_traffic(70);
      load_settings(8'($urandom), 8'($urandom), 8'($urandom));
      test_random_traffic(70);
      load_settings(CSR_REPLY_HDR_RESET, CSR_READ_ADDR_RESET, CSR_SYNC_ADDR_RESET);
      test_random_traffic(70);
   endtask

   // receiver holds off while words keep coming, so the queue fills and stalls input
   task automatic test_backpressure();
      int i;
      wait_all_words();
      pacing     = 1'b0;
      stall_left = HOLD_CYCLES;
      for (i = 0; i < 10; i++) send_word(any_word(CMD_SYNC));
      send_word(any_word(CMD_READ));
      send_reply(FAULT_NONE, pick8(), pick16(), 8, 1'b0);
      pacing = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : run_tests
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_REPLY_HDR;
      csr_wdata      = 8'h00;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values of the registers are in force for the first tests
      test_framing_extremes();
      test_reply_checks();
      test_random_traffic(50);
      test_settings_sweep();
      test_backpressure();

      wait_all_words();
      if (mismatches == 0 && due_wr == due_rd)
         $display("servo_bus_packet_framer_parser_tb: PASS");
      else
         $display("servo_bus_packet_framer_parser_tb: FAIL");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/sbpfp_pkg.sv
rtl/sbpfp_chan_if.sv
rtl/sbpfp_job_queue.sv
rtl/sbpfp_front.sv
rtl/sbpfp_back.sv
rtl/servo_bus_packet_framer_parser.sv
sim/servo_bus_packet_framer_parser_tb.sv
